FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the rate limiter.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rate limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define USRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rate limiter check failed");

`endif

FILE: sv/usrl_pkg.sv
// Shared types, constants and helper functions of the source rate limiter.
// Depends on nothing; every other file but assert_macros.svh imports it.
package usrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] RANK_LAST = IDX_W'(TABLE_ENTRIES - 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] MIN_FRAME_BYTES = 16'd42;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  PLAIN_IHL       = 4'd5;

    localparam logic [15:0] GUARDED_PORT_RESET = 16'd10100;
    localparam logic [15:0] RATE_MAX_RESET     = 16'd100;
    localparam logic [39:0] WINDOW_NS_RESET    = 40'd1000000000;

    localparam logic [1:0] CFG_GUARDED_PORT = 2'd0;
    localparam logic [1:0] CFG_RATE_MAX     = 2'd1;
    localparam logic [1:0] CFG_WINDOW_NS    = 2'd2;

    localparam logic [2:0] REASON_NONE    = 3'd0;
    localparam logic [2:0] REASON_NEW     = 3'd1;
    localparam logic [2:0] REASON_RESTART = 3'd2;
    localparam logic [2:0] REASON_WITHIN  = 3'd3;
    localparam logic [2:0] REASON_OVER    = 3'd4;

    // One classified frame as it waits between the front and the back.
    typedef struct packed {
        logic        eligible;
        logic [31:0] src;
        logic [63:0] now;
    } t_item;

    // Per-source window state kept in the back's memory.
    typedef struct packed {
        logic [63:0] start;
        logic [16:0] count;
    } t_entry;

    typedef struct packed {
        logic             lookup;
        logic [31:0]      lookup_key;
        logic             upd;
        logic             insert;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rank;
        logic [31:0]      ins_key;
    } t_tbl_req;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic [IDX_W-1:0] victim_idx;
    } t_tbl_rsp;

    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [TABLE_ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (v[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/usrl_front.sv
// Front end: accepts frame headers and decides whether they are subject to the rate limit.
// Depends on usrl_pkg; feeds usrl_fifo.
module usrl_front (
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [15:0]      i_frame_length,
    input  logic [15:0]      i_ether_type,
    input  logic [7:0]       i_ip_protocol,
    input  logic [3:0]       i_ip_header_words,
    input  logic [15:0]      i_udp_dest_port,
    input  logic [31:0]      i_source_ip,
    input  logic [63:0]      i_now_ns,
    input  logic [15:0]      i_guarded_port,
    input  logic             i_full,
    output logic             o_push,
    output usrl_pkg::t_item  o_item
);
    import usrl_pkg::*;

    logic w_eligible;

    assign w_eligible = (i_frame_length >= MIN_FRAME_BYTES)
                     && (i_ether_type == ETHERTYPE_IPV4)
                     && (i_ip_protocol == PROTO_UDP)
                     && (i_ip_header_words == PLAIN_IHL)
                     && (i_udp_dest_port == i_guarded_port);

    assign o_stall       = i_full;
    assign o_push        = i_valid && !i_full;
    assign o_item.eligible = w_eligible;
    assign o_item.src    = i_source_ip;
    assign o_item.now    = i_now_ns;

endmodule

FILE: sv/usrl_fifo.sv
// Short queue of classified frames between the front end and the back end.
// Depends on usrl_pkg.
module usrl_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  usrl_pkg::t_item  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output usrl_pkg::t_item  o_data
);
    import usrl_pkg::*;

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/usrl_table.sv
// Source table: associative key match, valid bits and true LRU ranks.
// Depends on usrl_pkg; driven by usrl_back.
module usrl_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usrl_pkg::t_tbl_req  i_req,
    output usrl_pkg::t_tbl_rsp  o_rsp
);
    import usrl_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_key  [TABLE_ENTRIES];
    logic [IDX_W-1:0]         r_rank [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_hit_vec;
    logic [TABLE_ENTRIES-1:0] w_match;
    logic [TABLE_ENTRIES-1:0] w_victim_vec;
    logic [IDX_W-1:0]         w_hit_rank;

    // Valid keys are unique, so at most one lane matches.
    always_comb begin
        w_hit_rank = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_match[i]      = r_valid[i] && (r_key[i] == i_req.lookup_key);
            w_victim_vec[i] = (r_rank[i] == RANK_LAST);
            if (r_hit_vec[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
        end
    end

    assign o_rsp.hit        = |r_hit_vec;
    assign o_rsp.hit_idx    = onehot_to_idx(r_hit_vec);
    assign o_rsp.hit_rank   = w_hit_rank;
    assign o_rsp.victim_idx = onehot_to_idx(w_victim_vec);

    always_ff @(posedge i_clk) begin
        if (i_req.lookup) begin
            r_hit_vec <= w_match;
        end
        if (i_req.upd && i_req.insert) begin
            r_key[i_req.idx] <= i_req.ins_key;
        end
    end

    // Touching an entry moves every more recent entry one rank down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_rank[i] <= IDX_W'(i);
            end
        end else if (i_req.upd) begin
            if (i_req.insert) begin
                r_valid[i_req.idx] <= 1'b1;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (IDX_W'(i) == i_req.idx) begin
                    r_rank[i] <= '0;
                end else if (r_rank[i] < i_req.rank) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/usrl_back.sv
// Back end: sequences table lookup, window memory access and the verdict.
// Depends on usrl_pkg; drives usrl_table and the result register.
module usrl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_rate_max,
    input  logic [39:0]         i_window_ns,
    input  logic                i_head_valid,
    input  usrl_pkg::t_item     i_head,
    output logic                o_pop,
    output usrl_pkg::t_tbl_req  o_tbl_req,
    input  usrl_pkg::t_tbl_rsp  i_tbl_rsp,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_drop,
    output logic [2:0]          o_reason,
    output logic [16:0]         o_window_count
);
    import usrl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_DIFF,
        S_EVAL
    } t_state;

    t_state           r_state;
    logic [31:0]      r_src;
    logic [63:0]      r_now;
    logic             r_hit;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rank;
    logic [63:0]      r_diff;
    t_entry           r_tab [TABLE_ENTRIES];
    t_entry           r_tab_q;
    logic             r_out_valid;
    logic             r_drop;
    logic [2:0]       r_reason;
    logic [16:0]      r_count;

    logic             w_out_free;
    logic             w_take_plain;
    logic             w_take_elig;
    logic             w_commit;
    logic [IDX_W-1:0] w_sel_idx;
    logic [IDX_W-1:0] w_sel_rank;
    logic [17:0]      w_cnt_inc;
    logic [17:0]      w_cap;
    logic [17:0]      w_cnt_sat;
    logic             w_expired;
    logic [2:0]       n_reason;
    logic [16:0]      n_count;
    t_entry           n_entry;

    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_take_plain = (r_state == S_IDLE) && i_head_valid && !i_head.eligible
                       && w_out_free;
    assign w_take_elig  = (r_state == S_IDLE) && i_head_valid && i_head.eligible;
    assign w_commit     = (r_state == S_EVAL) && w_out_free;
    assign o_pop        = w_take_plain || w_take_elig;

    assign w_sel_idx  = i_tbl_rsp.hit ? i_tbl_rsp.hit_idx : i_tbl_rsp.victim_idx;
    assign w_sel_rank = i_tbl_rsp.hit ? i_tbl_rsp.hit_rank : RANK_LAST;

    assign o_tbl_req.lookup     = w_take_elig;
    assign o_tbl_req.lookup_key = i_head.src;
    assign o_tbl_req.upd        = w_commit;
    assign o_tbl_req.insert     = !r_hit;
    assign o_tbl_req.idx        = r_idx;
    assign o_tbl_req.rank       = r_rank;
    assign o_tbl_req.ins_key    = r_src;

    // The count may sit above a lowered cap, so it is clamped after the increment.
    always_comb begin
        w_cnt_inc = {1'b0, r_tab_q.count} + 18'd1;
        w_cap     = {2'b00, i_rate_max} + 18'd1;
        w_cnt_sat = (w_cnt_inc > w_cap) ? w_cap : w_cnt_inc;
        w_expired = (r_diff >= {24'd0, i_window_ns});
        n_entry.start = r_now;
        n_entry.count = 17'd1;
        if (!r_hit) begin
            n_reason = REASON_NEW;
            n_count  = 17'd1;
        end else if (w_expired) begin
            n_reason = REASON_RESTART;
            n_count  = 17'd1;
        end else begin
            n_count       = w_cnt_sat[16:0];
            n_entry.start = r_tab_q.start;
            n_entry.count = w_cnt_sat[16:0];
            n_reason      = (w_cnt_sat > {2'b00, i_rate_max}) ? REASON_OVER : REASON_WITHIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_tab[r_idx] <= n_entry;
        end
        if (r_state == S_MATCH) begin
            r_tab_q <= r_tab[w_sel_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take_plain) begin
                        r_out_valid <= 1'b1;
                        r_drop      <= 1'b0;
                        r_reason    <= REASON_NONE;
                        r_count     <= '0;
                    end else if (w_take_elig) begin
                        r_src   <= i_head.src;
                        r_now   <= i_head.now;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_hit   <= i_tbl_rsp.hit;
                    r_idx   <= w_sel_idx;
                    r_rank  <= w_sel_rank;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= r_now - r_tab_q.start;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_drop      <= (n_reason == REASON_OVER);
                        r_reason    <= n_reason;
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_drop         = r_drop;
    assign o_reason       = r_reason;
    assign o_window_count = r_count;

endmodule

FILE: sv/udp_source_rate_limiter.sv
// Per-source fixed-window rate limiter for UDP frames on one guarded port.
//
// Input channel (i_valid / o_stall) takes the parsed header fields of one frame
// and its arrival time; a frame is transferred when i_valid is high and o_stall
// is low. Output channel (o_valid / i_stall) gives one verdict per frame, in
// order: drop flag, reason code and the source's count in its window.
// Configuration writes (i_cfg_valid / o_cfg_ready) set guarded port, rate limit
// and window length; o_cfg_ready is always high. Write only while idle.
//
// A frame that is not eligible goes from the queue straight into the result
// register; such frames can follow at one per cycle while i_stall stays low.
// An eligible frame goes through key match, window memory read, window difference,
// and update with verdict, in that order; the back end takes no new frame from
// the queue until that frame's verdict is in the result register.
// A two-entry queue lets the front end keep taking frames while the back end works.
// When the receiver stalls, the result register holds; the queue fills and then
// o_stall rises. Reset empties the table, orders the LRU ranks by entry index
// and loads the default configuration; there is no clearing pass.
module udp_source_rate_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [3:0]  i_ip_header_words,
    input  logic [15:0] i_udp_dest_port,
    input  logic [31:0] i_source_ip,
    input  logic [63:0] i_now_ns,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drop,
    output logic [2:0]  o_reason,
    output logic [16:0] o_window_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    import usrl_pkg::*;

    logic [15:0] r_guarded_port;
    logic [15:0] r_rate_max;
    logic [39:0] r_window_ns;

    logic        w_push;
    logic        w_full;
    logic        w_empty;
    logic        w_pop;
    t_item       w_in_item;
    t_item       w_head;
    t_tbl_req    w_tbl_req;
    t_tbl_rsp    w_tbl_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guarded_port <= GUARDED_PORT_RESET;
            r_rate_max     <= RATE_MAX_RESET;
            r_window_ns    <= WINDOW_NS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GUARDED_PORT: r_guarded_port <= i_cfg_data[15:0];
                CFG_RATE_MAX:     r_rate_max     <= i_cfg_data[15:0];
                CFG_WINDOW_NS:    r_window_ns    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    usrl_front u_front (
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_frame_length    (i_frame_length),
        .i_ether_type      (i_ether_type),
        .i_ip_protocol     (i_ip_protocol),
        .i_ip_header_words (i_ip_header_words),
        .i_udp_dest_port   (i_udp_dest_port),
        .i_source_ip       (i_source_ip),
        .i_now_ns          (i_now_ns),
        .i_guarded_port    (r_guarded_port),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_item            (w_in_item)
    );

    usrl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    usrl_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tbl_req),
        .o_rsp   (w_tbl_rsp)
    );

    usrl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rate_max     (r_rate_max),
        .i_window_ns    (r_window_ns),
        .i_head_valid   (!w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_tbl_req      (w_tbl_req),
        .i_tbl_rsp      (w_tbl_rsp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drop         (o_drop),
        .o_reason       (o_reason),
        .o_window_count (o_window_count)
    );

endmodule

FILE: sv/usrl_checker.sv
// Port-level checks on the verdicts of the rate limiter, bound to the top level.
// Depends on usrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_drop,
    input logic [2:0]  o_reason,
    input logic [16:0] o_window_count
);
    import usrl_pkg::*;

    logic        w_plain;
    logic        w_fresh;
    logic [20:0] w_verdict;

    assign w_plain   = o_valid && (o_reason == REASON_NONE);
    assign w_fresh   = o_valid && ((o_reason == REASON_NEW) || (o_reason == REASON_RESTART));
    assign w_verdict = {o_drop, o_reason, o_window_count};

    // A frame outside the guarded traffic always passes with a zero count.
    `USRL_ASSERT_IMP(a_plain_pass, i_clk, i_rst_n, w_plain, !o_drop && (o_window_count == 17'd0))

    // Only the over-limit verdict drops.
    `USRL_ASSERT_IMP(a_drop_reason, i_clk, i_rst_n, o_valid, o_drop == (o_reason == REASON_OVER))

    // A new source or a fresh window starts counting at one.
    `USRL_ASSERT_IMP(a_fresh_count, i_clk, i_rst_n, w_fresh, o_window_count == 17'd1)

    // A stalled verdict stays put.
    `USRL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(w_verdict))

endmodule

bind udp_source_rate_limiter usrl_checker u_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for udp_source_rate_limiter: sends parsed frame headers,
// predicts each pass/drop verdict with its own source table and checks results in order.
// Depends on usrl_pkg and the udp_source_rate_limiter module.
module testbench;
    import usrl_pkg::*;

    localparam logic [1:0]  CFG_UNUSED     = 2'd3;
    localparam logic [39:0] WINDOW_MAX     = 40'hff_ffff_ffff;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          POOL_MAX       = 128;

    typedef struct packed {
        logic [15:0] flen;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [15:0] dport;
        logic [31:0] src;
        logic [63:0] now;
    } t_frame;

    typedef struct packed {
        logic        drop;
        logic [2:0]  reason;
        logic [16:0] count;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_frame_length = '0;
    logic [15:0] i_ether_type = '0;
    logic [7:0]  i_ip_protocol = '0;
    logic [3:0]  i_ip_header_words = '0;
    logic [15:0] i_udp_dest_port = '0;
    logic [31:0] i_source_ip = '0;
    logic [63:0] i_now_ns = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_drop;
    logic [2:0]  o_reason;
    logic [16:0] o_window_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [39:0] i_cfg_data = '0;

    // Predicted configuration and source table.
    logic [15:0] cfg_port;
    logic [15:0] cfg_rate_max;
    logic [39:0] cfg_window;
    logic        tbl_valid [TABLE_ENTRIES];
    logic [31:0] tbl_src   [TABLE_ENTRIES];
    logic [63:0] tbl_start [TABLE_ENTRIES];
    logic [16:0] tbl_count [TABLE_ENTRIES];
    int          tbl_rank  [TABLE_ENTRIES];

    t_verdict    verdicts_due[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          idle_on = 1'b1;
    int          hold_len = 0;
    bit          result_taken = 1'b0;
    logic [63:0] clock_ns = '0;
    logic [31:0] source_pool [POOL_MAX];
    int          pool_size = 1;

    udp_source_rate_limiter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_frame_length    (i_frame_length),
        .i_ether_type      (i_ether_type),
        .i_ip_protocol     (i_ip_protocol),
        .i_ip_header_words (i_ip_header_words),
        .i_udp_dest_port   (i_udp_dest_port),
        .i_source_ip       (i_source_ip),
        .i_now_ns          (i_now_ns),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_drop            (o_drop),
        .o_reason          (o_reason),
        .o_window_count    (o_window_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void clear_table();
        cfg_port     = GUARDED_PORT_RESET;
        cfg_rate_max = RATE_MAX_RESET;
        cfg_window   = WINDOW_NS_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_src[i]   = '0;
            tbl_start[i] = '0;
            tbl_count[i] = '0;
            tbl_rank[i]  = i;
        end
    endfunction

    // Rank 0 is the most recent; every entry that was more recent slides down one.
    function automatic void promote_entry(input int e);
        int r;
        r = tbl_rank[e];
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_rank[i] < r) begin
                tbl_rank[i]++;
            end
        end
        tbl_rank[e] = 0;
    endfunction

    function automatic t_verdict rate_verdict(input t_frame f);
        t_verdict    v;
        int          hit;
        int          victim;
        logic [17:0] cnt;
        logic [17:0] cap;
        v = '0;
        v.reason = REASON_NONE;
        if (f.flen < MIN_FRAME_BYTES || f.etype != ETHERTYPE_IPV4 || f.proto != PROTO_UDP ||
            f.ihl != PLAIN_IHL || f.dport != cfg_port) begin
            return v;
        end
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_src[i] == f.src) begin
                hit = i;
            end
        end
        cap = 18'(cfg_rate_max) + 18'd1;
        if (hit < 0) begin
            victim = 0;
            for (int i = 1; i < TABLE_ENTRIES; i++) begin
                if (tbl_rank[i] > tbl_rank[victim]) begin
                    victim = i;
                end
            end
            tbl_valid[victim] = 1'b1;
            tbl_src[victim]   = f.src;
            tbl_start[victim] = f.now;
            tbl_count[victim] = 17'd1;
            promote_entry(victim);
            v.reason = REASON_NEW;
            cnt = 18'd1;
        end else begin
            promote_entry(hit);
            // The age is taken modulo 2^64, so a timestamp that wrapped still counts forward.
            if (f.now - tbl_start[hit] >= 64'(cfg_window)) begin
                tbl_start[hit] = f.now;
                tbl_count[hit] = 17'd1;
                v.reason = REASON_RESTART;
                cnt = 18'd1;
            end else begin
                cnt = 18'(tbl_count[hit]) + 18'd1;
                if (cnt > cap) begin
                    cnt = cap;
                end
                tbl_count[hit] = cnt[16:0];
                v.reason = (cnt > 18'(cfg_rate_max)) ? REASON_OVER : REASON_WITHIN;
            end
        end
        v.drop  = (v.reason == REASON_OVER);
        v.count = cnt[16:0];
        return v;
    endfunction

    function automatic t_frame well_formed(input logic [31:0] src, input logic [63:0] now);
        t_frame f;
        f.flen  = 16'd64;
        f.etype = ETHERTYPE_IPV4;
        f.proto = PROTO_UDP;
        f.ihl   = PLAIN_IHL;
        f.dport = cfg_port;
        f.src   = src;
        f.now   = now;
        return f;
    endfunction

    // Mostly eligible frames from the current source pool; one in five is broken or random.
    function automatic t_frame random_frame();
        t_frame      f;
        logic [63:0] span;
        span = 64'(cfg_window);
        case ($urandom_range(0, 9))
            0: clock_ns += span + rand64() % (span + 64'd1);
            1: clock_ns += rand64();
            default: clock_ns += rand64() % (span / 64'd32 + 64'd1);
        endcase
        f = well_formed(source_pool[$urandom_range(0, pool_size - 1)], clock_ns);
        f.flen = 16'($urandom_range(int'(MIN_FRAME_BYTES), 65535));
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 6))
                0: f.flen = 16'($urandom_range(0, int'(MIN_FRAME_BYTES) - 1));
                1: f.etype = 16'($urandom());
                2: f.proto = 8'($urandom());
                3: f.ihl = 4'($urandom());
                4: f.dport = 16'($urandom());
                5: f.src = $urandom();
                default: f = t_frame'({rand64(), rand64(), 28'($urandom())});
            endcase
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 100) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    task automatic send_frame(input t_frame f);
        int gap;
        bit took;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_frame_length    <= f.flen;
        i_ether_type      <= f.etype;
        i_ip_protocol     <= f.proto;
        i_ip_header_words <= f.ihl;
        i_udp_dest_port   <= f.dport;
        i_source_ip       <= f.src;
        i_now_ns          <= f.now;
        do begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end while (!took);
        verdicts_due.push_back(rate_verdict(f));
    endtask

    // Leaves i_cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [1:0] idx, input logic [39:0] value);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        case (idx)
            CFG_GUARDED_PORT: cfg_port = value[15:0];
            CFG_RATE_MAX:     cfg_rate_max = value[15:0];
            CFG_WINDOW_NS:    cfg_window = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] port, input logic [15:0] rmax,
                             input logic [39:0] win);
        write_reg(CFG_GUARDED_PORT, 40'(port));
        write_reg(CFG_RATE_MAX, 40'(rmax));
        write_reg(CFG_WINDOW_NS, win);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdicts_due.size() != 0);
    endtask

    // Default configuration: every eligibility check, window edges and timestamp wrap.
    task automatic test_header_checks();
        t_frame      f;
        logic [63:0] t0;
        logic [63:0] win;
        t0  = 64'h0000_0123_4567_89ab;
        win = 64'(WINDOW_NS_RESET);
        f = well_formed(32'hc0a8_0001, t0);
        f.flen = MIN_FRAME_BYTES - 16'd1;
        send_frame(f);
        f.flen = 16'd0;
        send_frame(f);
        f.flen = MIN_FRAME_BYTES;
        send_frame(f);
        f.flen = 16'hffff;
        f.now  = t0 + 64'd1;
        send_frame(f);
        f = well_formed(32'hc0a8_0001, t0 + 64'd2);
        f.etype = 16'h86dd;
        send_frame(f);
        f.etype = 16'hffff;
        send_frame(f);
        f = well_formed(32'hc0a8_0001, t0 + 64'd2);
        f.proto = 8'd6;
        send_frame(f);
        f.proto = 8'hff;
        send_frame(f);
        f = well_formed(32'hc0a8_0001, t0 + 64'd2);
        f.ihl = PLAIN_IHL - 4'd1;
        send_frame(f);
        f.ihl = 4'hf;
        send_frame(f);
        f = well_formed(32'hc0a8_0001, t0 + 64'd2);
        f.dport = cfg_port + 16'd1;
        send_frame(f);
        f.dport = 16'd0;
        send_frame(f);
        // Last nanosecond inside the window, then the first one outside it.
        send_frame(well_formed(32'hc0a8_0001, t0 + win - 64'd1));
        send_frame(well_formed(32'hc0a8_0001, t0 + win));
        send_frame(well_formed(32'h0000_0000, 64'd0));
        send_frame(well_formed(32'hffff_ffff, '1));
        send_frame(well_formed(32'hffff_ffff, win - 64'd2));
        send_frame(well_formed(32'hffff_ffff, win - 64'd1));
        wait_drained();
    endtask

    // Extreme limits: saturation, lowering the cap, zero rate, zero window, unused index.
    task automatic test_limits();
        logic [63:0] t;
        t = rand64();
        configure(16'hffff, 16'd1, WINDOW_MAX);
        send_frame(well_formed(32'h0a00_0001, t));
        send_frame(well_formed(32'h0a00_0001, t + 64'd5));
        send_frame(well_formed(32'h0a00_0001, t + 64'd9));
        wait_drained();
        write_reg(CFG_RATE_MAX, 40'd0);
        write_reg(CFG_UNUSED, 40'(rand64()));
        i_cfg_valid <= 1'b0;
        send_frame(well_formed(32'h0a00_0001, t + 64'd10));
        send_frame(well_formed(32'h0a00_0002, t + 64'd11));
        send_frame(well_formed(32'h0a00_0002, t + 64'd12));
        wait_drained();
        write_reg(CFG_WINDOW_NS, 40'd0);
        write_reg(CFG_GUARDED_PORT, 40'd0);
        i_cfg_valid <= 1'b0;
        send_frame(well_formed(32'h0a00_0002, t + 64'd12));
        send_frame(well_formed(32'h0a00_0002, t + 64'd13));
        wait_drained();
    endtask

    task automatic run_phase(input logic [15:0] port, input logic [15:0] rmax,
                             input logic [39:0] win, input int sources, input int frames,
                             input bit idle);
        configure(port, rmax, win);
        pool_size = sources;
        for (int i = 0; i < sources; i++) begin
            source_pool[i] = $urandom();
        end
        clock_ns = rand64();
        idle_on  = idle;
        repeat (frames) send_frame(random_frame());
        wait_drained();
        idle_on = 1'b1;
    endtask

    // The receiver holds off while frames keep coming, so the block must stall its input.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        repeat (24) send_frame(random_frame());
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_phase(16'd53, 16'd3, 40'd5000, 6, 110, 1'b1);
        run_phase(16'hffff, 16'd1, 40'd1, 10, 110, 1'b0);
        test_backpressure();
        // More sources than table entries, so the oldest ones keep getting evicted.
        run_phase(16'd0, 16'hffff, WINDOW_MAX, 100, 120, 1'b1);
        run_phase(16'($urandom()), 16'd0, 40'(rand64()), 4, 100, 1'b1);
        run_phase(16'($urandom()), 16'($urandom_range(2, 8)), 40'd0, 70, 100, 1'b1);
        run_phase(GUARDED_PORT_RESET, 16'd5, 40'd1000000, 66, 110, 1'b1);
    endtask

    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (result_taken) begin
                result_taken = 1'b0;
                n = idle_on ? $urandom_range(0, 4) : 0;
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Inputs only change at rising edges, so the falling edge shows what the next edge takes.
    always @(negedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                result_taken = 1'b1;
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected verdict, reason", 64'(o_reason), '0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_drop !== want.drop) begin
                        report_mismatch("drop", 64'(o_drop), 64'(want.drop));
                    end
                    if (o_reason !== want.reason) begin
                        report_mismatch("reason", 64'(o_reason), 64'(want.reason));
                    end
                    if (o_window_count !== want.count) begin
                        report_mismatch("window_count", 64'(o_window_count), 64'(want.count));
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        clear_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_checks();
        test_limits();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            report_mismatch("verdicts still expected", 64'(verdicts_due.size()), '0);
        end
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/usrl_pkg.sv
sv/usrl_front.sv
sv/usrl_fifo.sv
sv/usrl_table.sv
sv/usrl_back.sv
sv/udp_source_rate_limiter.sv
sv/usrl_checker.sv
bench/testbench.sv
